### hw/rtl/rxs_pkg.sv
// shared types, constants and helper functions for the record exchange sort
package rxs_pkg;

    // record field widths and store sizing
    localparam int ROLL_W          = 16;
    localparam int MARK_W          = 7;
    localparam int KEY_W           = 10;
    localparam int SUBJECTS        = 6;
    localparam int DEF_MAX_RECORDS = 64;

    // mark ceiling and class limits on the total (percentages 80/60/40)
    localparam logic [MARK_W-1:0] MARK_MAX     = MARK_W'(100);
    localparam logic [KEY_W-1:0]  LIMIT_DIST   = KEY_W'(80 * SUBJECTS);
    localparam logic [KEY_W-1:0]  LIMIT_FIRST  = KEY_W'(60 * SUBJECTS);
    localparam logic [KEY_W-1:0]  LIMIT_SECOND = KEY_W'(40 * SUBJECTS);

    // class codes
    typedef enum logic [1:0] {
        CLASS_DIST   = 2'd0,
        CLASS_FIRST  = 2'd1,
        CLASS_SECOND = 2'd2,
        CLASS_FAIL   = 2'd3
    } t_class;

    // input word
    typedef struct packed {
        logic [ROLL_W-1:0] roll_number;
        logic [MARK_W-1:0] mark_a;
        logic [MARK_W-1:0] mark_b;
        logic [MARK_W-1:0] mark_c;
        logic [MARK_W-1:0] mark_d;
        logic [MARK_W-1:0] mark_e;
        logic [MARK_W-1:0] mark_f;
        logic              last_record;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [ROLL_W-1:0] sorted_roll;
        logic [KEY_W-1:0]  sorted_total;
        logic [1:0]        class_code;
        logic              final_result;
    } t_out_word;

    // one store entry
    typedef struct packed {
        logic [ROLL_W-1:0] roll;
        logic [KEY_W-1:0]  key;
    } t_entry;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_HOLD,
        S_SCAN,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    // clip a mark to the top of its range
    function automatic logic [MARK_W-1:0] sat_mark(input logic [MARK_W-1:0] m);
        sat_mark = (m > MARK_MAX) ? MARK_MAX : m;
    endfunction

    // class code from a total
    function automatic t_class class_of(input logic [KEY_W-1:0] total);
        if (total >= LIMIT_DIST) begin
            class_of = CLASS_DIST;
        end else if (total >= LIMIT_FIRST) begin
            class_of = CLASS_FIRST;
        end else if (total >= LIMIT_SECOND) begin
            class_of = CLASS_SECOND;
        end else begin
            class_of = CLASS_FAIL;
        end
    endfunction

endpackage

### hw/rtl/record_exchange_sort.sv
// record store with exchange sort over a single compare unit and ordered read-out
// load: one record per cycle, input accepted in every cycle while loading
// sort: runs for n >= 2 stored records, one compare per cycle,
//   set by the single read and single write port of the record store
// emit: words in ascending order of total, each held while stalled; the next is read once it is taken
// reset (synchronous, active low) clears the sequencer, record count and output valid;
//   store contents are not cleared
module record_exchange_sort
    import rxs_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_jp, n_jp;
    logic [CW-1:0]   r_k, n_k;
    t_entry          r_cur, n_cur;
    t_out_word       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    // record store, one write and one registered read per cycle
    t_entry          r_mem [MAX_RECORDS];
    t_entry          r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    t_entry          mem_wd;
    logic [AW-1:0]   mem_ra;

    logic            in_acc;
    logic [KEY_W-1:0] in_total;
    logic [CW-1:0]   i_inc;
    logic [CW-1:0]   i_inc2;
    logic [CW-1:0]   k_inc;
    logic            more_pass;
    logic            swap;

    assign in_acc = i_in_valid && !o_in_stall;

    // sum of clipped marks
    assign in_total = KEY_W'(sat_mark(i_in_word.mark_a)) + KEY_W'(sat_mark(i_in_word.mark_b))
                    + KEY_W'(sat_mark(i_in_word.mark_c)) + KEY_W'(sat_mark(i_in_word.mark_d))
                    + KEY_W'(sat_mark(i_in_word.mark_e)) + KEY_W'(sat_mark(i_in_word.mark_f));

    assign i_inc     = r_i + CW'(1);
    assign i_inc2    = r_i + CW'(2);
    assign k_inc     = r_k + CW'(1);
    assign more_pass = (CW + 1)'(i_inc2) < (CW + 1)'(r_count);
    assign swap      = r_cur.key >= r_rd.key;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_word.last_record) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_count > CW'(1)) ? S_HOLD : S_EMIT_LD;
            end
            S_HOLD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_j >= r_count) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                n_state = more_pass ? S_HOLD : S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (!i_out_stall) begin
                    n_state = r_out.final_result ? S_LOAD : S_EMIT_LD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_jp        = r_jp;
        n_k         = r_k;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = r_cur;
        mem_ra      = '0;
        case (r_state)
            // store incoming records while there is room
            S_LOAD: begin
                n_i = '0;
                n_j = CW'(1);
                if (in_acc && (r_count < CW'(MAX_RECORDS))) begin
                    mem_we      = 1'b1;
                    mem_wa      = r_count[AW-1:0];
                    mem_wd.roll = i_in_word.roll_number;
                    mem_wd.key  = in_total;
                    n_count     = r_count + CW'(1);
                end
            end
            // fetch entry 0
            S_START: begin
                mem_ra = '0;
                n_k    = '0;
            end
            // entry i is taken into the held register at the start of the pass
            S_HOLD: begin
                n_cur  = r_rd;
                mem_ra = r_j[AW-1:0];
                n_jp   = r_j[AW-1:0];
                n_j    = r_j + CW'(1);
            end
            // compare held entry against entry j, swap on greater or equal
            S_SCAN: begin
                if (swap) begin
                    mem_we = 1'b1;
                    mem_wa = r_jp;
                    mem_wd = r_cur;
                    n_cur  = r_rd;
                end
                if (r_j < r_count) begin
                    mem_ra = r_j[AW-1:0];
                    n_jp   = r_j[AW-1:0];
                    n_j    = r_j + CW'(1);
                end
            end
            // write back the minimum to entry i and start the next pass, if any
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_i[AW-1:0];
                mem_wd = r_cur;
                mem_ra = i_inc[AW-1:0];
                n_i    = i_inc;
                n_j    = i_inc2;
            end
            S_EMIT_RD: begin
                mem_ra = '0;
            end
            // load the output word from the store
            S_EMIT_LD: begin
                n_out.sorted_roll  = r_rd.roll;
                n_out.sorted_total = r_rd.key;
                n_out.class_code   = class_of(r_rd.key);
                n_out.final_result = (k_inc == r_count);
                n_out_valid        = 1'b1;
            end
            // wait for the word to be taken
            S_EMIT_WAIT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_k         = k_inc;
                    mem_ra      = k_inc[AW-1:0];
                    if (r_out.final_result) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_jp  <= n_jp;
        r_k   <= n_k;
        r_cur <= n_cur;
        r_out <= n_out;
    end

    // record store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### hw/rtl/rxs_checker.sv
// port-level checks for the record exchange sort, bound to record_exchange_sort
module rxs_checker
    import rxs_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input t_in_word  i_in_word,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_word o_out_word,
    input logic      i_out_stall
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // no loading while words are being emitted
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while emitting");

    // the closing record stops intake and no word is yet valid
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.last_record |=> o_in_stall && !o_out_valid)
        else $error("intake not stopped after last record");

    // after the final word the block is ready to load again
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_word.final_result |=> !o_in_stall && !o_out_valid)
        else $error("block not back to loading after final word");

    // class code agrees with the total
    a_class_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_word.sorted_total >= LIMIT_DIST && o_out_word.class_code == CLASS_DIST) ||
            (o_out_word.sorted_total < LIMIT_DIST && o_out_word.sorted_total >= LIMIT_FIRST &&
             o_out_word.class_code == CLASS_FIRST) ||
            (o_out_word.sorted_total < LIMIT_FIRST && o_out_word.sorted_total >= LIMIT_SECOND &&
             o_out_word.class_code == CLASS_SECOND) ||
            (o_out_word.sorted_total < LIMIT_SECOND && o_out_word.class_code == CLASS_FAIL))
        else $error("class code does not match total");

endmodule

bind record_exchange_sort rxs_checker u_rxs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_word   (i_in_word),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);
